// ----- rtl/yc2rgb_pkg.sv -----
`timescale 1ns / 1ps

package yc2rgb_pkg;

  // Default geometry
  localparam int unsigned IMAGE_WIDTH_DEF      = 160;
  localparam int unsigned IMAGE_HEIGHT_DEF     = 128;
  localparam int unsigned CHROMA_SUBSAMPLE_DEF = 4;
  localparam int unsigned SCREEN_WIDTH_DEF     = 352;

  // Stream and register port widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned ADDR_W      = 18;

  // BT.709 in Q21
  localparam logic signed [23:0] K_RED_CR = 24'sd3302595;
  localparam logic signed [23:0] K_GRN_CB = 24'sd392796;
  localparam logic signed [23:0] K_GRN_CR = 24'sd981677;
  localparam logic signed [23:0] K_BLU_CB = 24'sd3891475;
  localparam int unsigned        Q_SHIFT  = 21;
  localparam logic signed [8:0]  CHROMA_BIAS = 9'sd64;
  localparam logic signed [11:0] CH_MAX      = 12'sd127;

  localparam logic [6:0] ROW_OFFSET_RST = 7'd0;
  localparam logic [4:0] COL_OFFSET_RST = 5'd10;

  typedef enum logic {
    REQ_STORE   = 1'b0,
    REQ_CONVERT = 1'b1
  } req_t;

  typedef enum logic {
    REG_ROW_OFFSET = 1'b0,
    REG_COL_OFFSET = 1'b1
  } cfg_reg_t;

endpackage

// ----- rtl/ycbcr_to_rgb555_upscale_writer_core.sv -----
`timescale 1ns / 1ps
// A convert beat passes stage 1, stage 2 and the output register, which sends the four write
//   beats of its 2x2 block before taking the next pixel; store beats are taken every cycle
//   unless a convert waits in stage 1, and produce no output.
// Chroma store is a 1-write/1-read RAM with registered read; entries are undefined until written.
// Reset (rst_n, synchronous): clears pipeline valids and beat counter; offsets return to
//   row 0, column 10.

module ycbcr_to_rgb555_upscale_writer_core
  import yc2rgb_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH      = IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT     = IMAGE_HEIGHT_DEF,
  parameter int unsigned CHROMA_SUBSAMPLE = CHROMA_SUBSAMPLE_DEF,
  parameter int unsigned SCREEN_WIDTH     = SCREEN_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pix_row[6:0], pix_col[14:7], luma[22:15], chroma_blue[30:23], chroma_red[38:31]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  logic                   in_tuser,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // fb_address[17:0], low_port_byte[25:18], high_port_byte[33:26]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // Chroma grid geometry
  localparam int unsigned CH_COLS  = IMAGE_WIDTH / CHROMA_SUBSAMPLE;
  localparam int unsigned CH_ROWS  = IMAGE_HEIGHT / CHROMA_SUBSAMPLE;
  localparam int unsigned CH_DEPTH = CH_COLS * CH_ROWS;
  localparam int unsigned CH_AW    = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
  localparam logic [8:0]  CH_ROWS_W = 9'(CH_ROWS);
  localparam logic [8:0]  CH_COLS_W = 9'(CH_COLS);
  localparam logic [ADDR_W-1:0] SW_A      = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] SW_BACK_A = ADDR_W'(1) - SW_A;  // next column, row above

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [6:0] row_off_r, row_off_nxt;
  logic [4:0] col_off_r, col_off_nxt;
  logic       cfg_wr;
  cfg_reg_t   cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);

  always_comb begin
    row_off_nxt = row_off_r;
    col_off_nxt = col_off_r;
    cfg_prdata  = '0;
    unique case (cfg_sel)
      REG_ROW_OFFSET: begin
        cfg_prdata = CFG_DATA_W'(row_off_r);
        if (cfg_wr) begin
          row_off_nxt = cfg_pwdata[6:0];
        end
      end
      REG_COL_OFFSET: begin
        cfg_prdata = CFG_DATA_W'(col_off_r);
        if (cfg_wr) begin
          col_off_nxt = cfg_pwdata[4:0];
        end
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_off_r <= ROW_OFFSET_RST;
      col_off_r <= COL_OFFSET_RST;
    end else begin
      row_off_r <= row_off_nxt;
      col_off_r <= col_off_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Position -> chroma position tables (built at elaboration)
  // ---------------------------------------------------------------------------
  logic [6:0] crow_tbl [128];
  logic [7:0] ccol_tbl [256];

  for (genvar i = 0; i < 128; i++) begin : g_row_tbl
    localparam int unsigned Q = i / CHROMA_SUBSAMPLE;
    assign crow_tbl[i] = 7'(Q);
  end

  for (genvar i = 0; i < 256; i++) begin : g_col_tbl
    localparam int unsigned Q = i / CHROMA_SUBSAMPLE;
    assign ccol_tbl[i] = 8'(Q);
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register; stores write the chroma RAM, converts read it
  // ---------------------------------------------------------------------------
  logic       s1_vld_r, s1_vld_nxt;
  req_t       s1_type_r;
  logic [6:0] s1_row_r;
  logic [7:0] s1_col_r, s1_luma_r, s1_cb_r, s1_cr_r;

  logic        s1_go, s1_rd;
  logic [6:0]  sel_row;
  logic [7:0]  sel_col;
  logic        in_grid;
  logic [15:0] idx_full;
  logic [CH_AW-1:0] ch_idx;
  logic        ram_we;
  logic [15:0] ram_rdata;

  // Stage 2 / output handshake signals used by stage 1
  logic s2_vld_r, s2_free, out_free;

  assign sel_row  = (s1_type_r == REQ_CONVERT) ? crow_tbl[s1_row_r] : s1_row_r;
  assign sel_col  = (s1_type_r == REQ_CONVERT) ? ccol_tbl[s1_col_r] : s1_col_r;
  assign in_grid  = ({2'b0, sel_row} < CH_ROWS_W) && ({1'b0, sel_col} < CH_COLS_W);
  assign idx_full = 16'(sel_row) * 16'(CH_COLS) + 16'(sel_col);
  assign ch_idx   = idx_full[CH_AW-1:0];

  // stores retire from stage 1 at once; converts wait for stage 2
  assign s1_go     = s1_vld_r && ((s1_type_r == REQ_STORE) || s2_free);
  assign s1_rd     = s1_vld_r && (s1_type_r == REQ_CONVERT) && s2_free;
  assign ram_we    = s1_vld_r && (s1_type_r == REQ_STORE) && in_grid;
  assign in_tready = !s1_vld_r || s1_go;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_type_r <= req_t'(in_tuser);
      s1_row_r  <= in_tdata[6:0];
      s1_col_r  <= in_tdata[14:7];
      s1_luma_r <= in_tdata[22:15];
      s1_cb_r   <= in_tdata[30:23];
      s1_cr_r   <= in_tdata[38:31];
    end
  end

  yc2rgb_ram #(
    .WIDTH (16),
    .DEPTH (CH_DEPTH)
  ) u_chroma_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_idx),
    .wdata ({s1_cr_r, s1_cb_r}),
    .re    (s1_rd),
    .raddr (ch_idx),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: chroma arrives from RAM; color math and base address
  // ---------------------------------------------------------------------------
  logic       s2_vld_nxt, s2_adv;
  logic [6:0] s2_row_r;
  logic [7:0] s2_col_r, s2_luma_r;
  logic       s2_grid_r;
  logic [7:0] cb_use, cr_use, low_byte, high_byte;
  logic [7:0] row_sum;
  logic [8:0] scr_row;
  logic [9:0] scr_col;
  logic [ADDR_W-1:0] base_addr;

  assign s2_adv  = s2_vld_r && out_free;
  assign s2_free = !s2_vld_r || out_free;

  always_comb begin
    s2_vld_nxt = s2_vld_r;
    if (s2_free) begin
      s2_vld_nxt = s1_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rd) begin
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_luma_r <= s1_luma_r;
      s2_grid_r <= in_grid;
    end
  end

  // off-grid chroma reads as raw zero
  assign cb_use = s2_grid_r ? ram_rdata[7:0]  : 8'd0;
  assign cr_use = s2_grid_r ? ram_rdata[15:8] : 8'd0;

  yc2rgb_cvt u_cvt (
    .luma      (s2_luma_r),
    .cb_raw    (cb_use),
    .cr_raw    (cr_use),
    .low_byte  (low_byte),
    .high_byte (high_byte)
  );

  // top-left pixel of the 2x2 block; wraps mod 2^18
  assign row_sum   = {1'b0, row_off_r} + {1'b0, s2_row_r};
  assign scr_row   = {row_sum, 1'b0};
  assign scr_col   = {(({4'b0, col_off_r}) + {1'b0, s2_col_r}), 1'b0};
  assign base_addr = ADDR_W'(scr_row) * SW_A + ADDR_W'(scr_col);

  // ---------------------------------------------------------------------------
  // Output register: four write beats per pixel, order (r,c) = 00, 10, 01, 11
  // ---------------------------------------------------------------------------
  logic              o_vld_r, o_vld_nxt;
  logic [1:0]        beat_r, beat_nxt;
  logic [ADDR_W-1:0] o_addr_r, o_addr_nxt;
  logic [7:0]        o_low_r, o_high_r;
  logic              beat_take, last_beat;

  assign last_beat = (beat_r == 2'd3);
  assign beat_take = o_vld_r && out_tready;
  assign out_free  = !o_vld_r || (out_tready && last_beat);

  always_comb begin
    o_vld_nxt  = o_vld_r;
    beat_nxt   = beat_r;
    o_addr_nxt = o_addr_r;
    priority if (s2_adv) begin
      o_vld_nxt  = 1'b1;
      beat_nxt   = 2'd0;
      o_addr_nxt = base_addr;
    end else if (beat_take && last_beat) begin
      o_vld_nxt = 1'b0;
    end else if (beat_take) begin
      beat_nxt   = beat_r + 2'd1;
      o_addr_nxt = o_addr_r + ((beat_r == 2'd1) ? SW_BACK_A : SW_A);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
      beat_r  <= 2'd0;
    end else begin
      o_vld_r <= o_vld_nxt;
      beat_r  <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_addr_r <= o_addr_nxt;
    if (s2_adv) begin
      o_low_r  <= low_byte;
      o_high_r <= high_byte;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tlast  = last_beat;
  assign out_tdata  = {6'b0, o_high_r, o_low_r, o_addr_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a pixel keeps its beats coming until the fourth
  a_beats_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_take && !last_beat) |=> (o_vld_r && (beat_r == $past(beat_r) + 2'd1)))
    else $error("write beat sequence broken");

  // second beat is one screen row below the first
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_take && (beat_r == 2'd0)) |=> (o_addr_r == $past(o_addr_r) + SW_A))
    else $error("row step of 2x2 block wrong");

  // color bytes hold across the beats of one pixel
  a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_take && !last_beat) |=> ({o_high_r, o_low_r} == $past({o_high_r, o_low_r})))
    else $error("color bytes changed inside a block");

  // a new pixel only enters the output register when it is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (o_vld_r && !(out_tready && last_beat)) |-> !s2_adv)
    else $error("output register overwritten");

endmodule

// ----- rtl/yc2rgb_ram.sv -----
`timescale 1ns / 1ps

module yc2rgb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1280,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/yc2rgb_cvt.sv -----
`timescale 1ns / 1ps

module yc2rgb_cvt
  import yc2rgb_pkg::*;
(
  input  logic [7:0] luma,
  input  logic [7:0] cb_raw,
  input  logic [7:0] cr_raw,
  output logic [7:0] low_byte,
  output logic [7:0] high_byte
);

  // clamp to 0..127, then keep the top five bits
  function automatic logic [4:0] to5(input logic signed [11:0] v);
    logic [4:0] res;
    if (v < 12'sd0) begin
      res = 5'd0;
    end else if (v > CH_MAX) begin
      res = 5'd31;
    end else begin
      res = v[6:2];
    end
    return res;
  endfunction

  logic signed [8:0]  cb_s, cr_s;
  logic signed [32:0] cb_x, cr_x, y_q;
  logic signed [32:0] r_acc, g_acc, b_acc;
  logic signed [11:0] r_v, g_v, b_v;
  logic [4:0]         r5, g5, b5;

  assign cb_s = $signed({1'b0, cb_raw}) - CHROMA_BIAS;
  assign cr_s = $signed({1'b0, cr_raw}) - CHROMA_BIAS;
  assign cb_x = 33'(cb_s);
  assign cr_x = 33'(cr_s);
  assign y_q  = $signed({4'b0, luma, 21'b0});

  assign r_acc = y_q + cr_x * 33'(K_RED_CR);
  assign g_acc = y_q - cb_x * 33'(K_GRN_CB) - cr_x * 33'(K_GRN_CR);
  assign b_acc = y_q + cb_x * 33'(K_BLU_CB);

  // floor shift: the top bits of a two's complement word
  assign r_v = r_acc[32:Q_SHIFT];
  assign g_v = g_acc[32:Q_SHIFT];
  assign b_v = b_acc[32:Q_SHIFT];

  assign r5 = to5(r_v);
  assign g5 = to5(g_v);
  assign b5 = to5(b_v);

  assign low_byte  = {g5[1:0], b5, 1'b0};
  assign high_byte = {r5, g5[4:2]};

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the YCbCr-to-RGB555 2x2 upscaling framebuffer writer.
// Input beats are planned here, driven onto in_*, and run through a local model
// of the block when they are accepted. The resulting framebuffer writes queue
// up and are matched, in order, against the out_* beats.
module testbench;
  import yc2rgb_pkg::*;

  localparam int SUB          = CHROMA_SUBSAMPLE_DEF;
  localparam int CH_COLS      = IMAGE_WIDTH_DEF / SUB;
  localparam int CH_ROWS      = IMAGE_HEIGHT_DEF / SUB;
  localparam int CH_DEPTH     = CH_COLS * CH_ROWS;
  localparam int HOLD_CYCLES  = 160;  // long sink hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 8;    // margin past the pipeline depth; store beats give no output

  typedef struct packed {
    req_t       req;
    logic [6:0] row;
    logic [7:0] col;
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
  } pix_item_t;

  // One planned input beat. When typed is set, the first write's address and
  // both port bytes are given by hand instead of by the model.
  typedef struct {
    pix_item_t   it;
    bit          typed;
    logic [17:0] addr0;
    logic [7:0]  low;
    logic [7:0]  high;
  } beat_plan_t;

  typedef struct {
    logic [17:0] addr;
    logic [7:0]  low;
    logic [7:0]  high;
    logic        last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;

  always #1 clk = ~clk;

  ycbcr_to_rgb555_upscale_writer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Model state: chroma stores and shadow offsets.
  logic [7:0] cb_mem [CH_DEPTH];
  logic [7:0] cr_mem [CH_DEPTH];
  logic [6:0] row_off = ROW_OFFSET_RST;
  logic [4:0] col_off = COL_OFFSET_RST;

  beat_plan_t sent_q[$];       // driven beats, oldest first, popped on acceptance
  fb_write_t  fb_writes_q[$];  // framebuffer writes still to come out
  int         mismatches = 0;

  // Generator bookkeeping: chroma entries already stored, so that converts
  // only ever fetch written entries.
  bit gen_written [CH_DEPTH];
  int written_list[$];

  bit calm = 1'b0;           // last stretch: no idling on either side
  bit long_hold_req = 1'b0;  // asks the sink for one long hold-off

  function automatic beat_plan_t plan(req_t req, int row, int col, int luma, int cb, int cr,
                                      bit typed = 1'b0, int addr0 = 0, int low = 0,
                                      int high = 0);
    beat_plan_t p;
    p.it.req  = req;
    p.it.row  = row[6:0];
    p.it.col  = col[7:0];
    p.it.luma = luma[7:0];
    p.it.cb   = cb[7:0];
    p.it.cr   = cr[7:0];
    p.typed   = typed;
    p.addr0   = addr0[17:0];
    p.low     = low[7:0];
    p.high    = high[7:0];
    return p;
  endfunction

  // Convert somewhere inside the 4x4 image block that shares one chroma entry.
  function automatic beat_plan_t convert_near(int crow, int ccol);
    return plan(REQ_CONVERT, crow * SUB + $urandom_range(0, SUB - 1),
                ccol * SUB + $urandom_range(0, SUB - 1), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  function automatic logic [4:0] chan5(longint v);
    if (v > longint'(CH_MAX)) v = longint'(CH_MAX);
    if (v < 0) v = 0;
    return 5'(v / 4);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Model of one accepted beat: stores update the chroma memories, converts
  // push their four 2x2 writes in (0,0) (1,0) (0,1) (1,1) order.
  task automatic predict_writes(input beat_plan_t b);
    int crow, ccol, idx, sr, sc, a, dr, dc;
    longint y, cbv, crv, rv, gv, bv;
    logic [4:0] r5, g5, b5;
    fb_write_t w;
    if (b.it.req == REQ_STORE) begin
      // stores off the chroma grid are dropped
      if (b.it.row < CH_ROWS && b.it.col < CH_COLS) begin
        idx = b.it.row * CH_COLS + b.it.col;
        cb_mem[idx] = b.it.cb;
        cr_mem[idx] = b.it.cr;
      end
      return;
    end
    crow = b.it.row / SUB;
    ccol = b.it.col / SUB;
    cbv = 0;
    crv = 0;
    // fetch off the grid sees raw chroma of zero
    if (crow < CH_ROWS && ccol < CH_COLS) begin
      idx = crow * CH_COLS + ccol;
      cbv = cb_mem[idx];
      crv = cr_mem[idx];
    end
    cbv -= longint'(CHROMA_BIAS);
    crv -= longint'(CHROMA_BIAS);
    y  = longint'(b.it.luma) <<< Q_SHIFT;
    rv = (y + longint'(K_RED_CR) * crv) >>> Q_SHIFT;
    gv = (y - longint'(K_GRN_CB) * cbv - longint'(K_GRN_CR) * crv) >>> Q_SHIFT;
    bv = (y + longint'(K_BLU_CB) * cbv) >>> Q_SHIFT;
    r5 = chan5(rv);
    g5 = chan5(gv);
    b5 = chan5(bv);
    w.low  = b.typed ? b.low  : {g5[1:0], b5, 1'b0};
    w.high = b.typed ? b.high : {r5, g5[4:2]};
    sr = 2 * (row_off + b.it.row);
    sc = 2 * (col_off + b.it.col);
    for (int k = 0; k < 4; k++) begin
      dr = k & 1;
      dc = k >> 1;
      if (b.typed) a = b.addr0 + dr * SCREEN_WIDTH_DEF + dc;
      else a = (sr + dr) * SCREEN_WIDTH_DEF + sc + dc;
      w.addr = a[17:0];  // address wraps at 18 bits
      w.last = (k == 3);
      fb_writes_q.push_back(w);
    end
  endtask

  // Input side: beats enter the model at the edge they are accepted.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_writes(sent_q.pop_front());
  end

  // Output side: every write beat is matched against the oldest expectation.
  always @(posedge clk) begin : fb_check
    fb_write_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (fb_writes_q.size() == 0) begin
        $display("%0t fb write mismatch: expected none, actual addr %h data %h last %b",
                 $time, out_tdata[17:0], out_tdata[33:18], out_tlast);
        mismatches++;
      end else begin
        w = fb_writes_q.pop_front();
        check_field("fb_address", 32'(w.addr), 32'(out_tdata[17:0]));
        check_field("low_port_byte", 32'(w.low), 32'(out_tdata[25:18]));
        check_field("high_port_byte", 32'(w.high), 32'(out_tdata[33:26]));
        check_field("last_write", 32'(w.last), 32'(out_tlast));
      end
    end
  end

  // Sink: random ready bursts, one long hold-off on request, steady when calm.
  initial begin : fb_sink
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Drives one beat and returns at the edge that takes it. Valid stays high
  // afterwards so back-to-back beats need no extra assignment.
  task automatic send_beat(input beat_plan_t b);
    int idx;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (b.it.req == REQ_STORE && b.it.row < CH_ROWS && b.it.col < CH_COLS) begin
      idx = b.it.row * CH_COLS + b.it.col;
      if (!gen_written[idx]) begin
        gen_written[idx] = 1'b1;
        written_list.push_back(idx);
      end
    end
    sent_q.push_back(b);
    in_tvalid <= 1'b1;
    in_tuser  <= b.it.req;
    in_tdata  <= {1'b0, b.it.cr, b.it.cb, b.it.luma, b.it.col, b.it.row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // APB transfer plus one idle cycle, so the next transfer never retimes
  // psel inside the same step.
  task automatic apb_xfer(input bit wr, input cfg_reg_t r, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offsets change only with the block drained, then are read back.
  task automatic program_offsets(input logic [6:0] r, input logic [4:0] c);
    logic [31:0] rd;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fb_writes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_xfer(1'b1, REG_ROW_OFFSET, 32'(r), rd);
    apb_xfer(1'b1, REG_COL_OFFSET, 32'(c), rd);
    row_off = r;
    col_off = c;
    apb_xfer(1'b0, REG_ROW_OFFSET, '0, rd);
    check_field("row_offset", 32'(r), 32'(rd[6:0]));
    apb_xfer(1'b0, REG_COL_OFFSET, '0, rd);
    check_field("col_offset", 32'(c), 32'(rd[4:0]));
  endtask

  // Mostly well-formed traffic: store a chroma pair, then convert pixels that
  // use it. The rest is off-grid stores, off-grid converts and revisits.
  task automatic random_run(input int n_items);
    int sent, pick, crow, ccol, idx;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        crow = $urandom_range(0, CH_ROWS - 1);
        ccol = $urandom_range(0, CH_COLS - 1);
        idx  = crow * CH_COLS + ccol;
        if (!gen_written[idx] || $urandom_range(0, 1) == 1) begin
          send_beat(plan(REQ_STORE, crow, ccol, $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255)));
          sent++;
        end
        repeat ($urandom_range(1, 4)) begin
          send_beat(convert_near(crow, ccol));
          sent++;
        end
      end else if (pick == 7) begin
        if ($urandom_range(0, 1) == 1)
          send_beat(plan(REQ_STORE, $urandom_range(CH_ROWS, 127), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255)));
        else
          send_beat(plan(REQ_STORE, $urandom_range(0, 127), $urandom_range(CH_COLS, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255)));
        sent++;
      end else if (pick == 8 || written_list.size() == 0) begin
        // pixel column past the image: chroma fetch falls off the grid
        send_beat(plan(REQ_CONVERT, $urandom_range(0, 127),
                       $urandom_range(IMAGE_WIDTH_DEF, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255)));
        sent++;
      end else begin
        idx = written_list[$urandom_range(0, written_list.size() - 1)];
        send_beat(convert_near(idx / CH_COLS, idx % CH_COLS));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    beat_plan_t dir_tab[$];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // Directed table, run with reset offsets (row 0, col 10).
    // Neutral chroma at entry (0,0): black and full white are typed in.
    dir_tab.push_back(plan(REQ_STORE,     0,   0,   0,  64,  64));
    dir_tab.push_back(plan(REQ_CONVERT,   0,   0,   0,   0,   0, 1'b1,  20, 8'h00, 8'h00));
    dir_tab.push_back(plan(REQ_CONVERT,   1,   3, 255,   0,   0, 1'b1, 730, 8'hFE, 8'hFF));
    // chroma extremes, so channels clamp high and low
    dir_tab.push_back(plan(REQ_STORE,     0,   1,   0, 255, 255));
    dir_tab.push_back(plan(REQ_CONVERT,   2,   4, 255,   0,   0));
    dir_tab.push_back(plan(REQ_CONVERT,   0,   7,   0,   0,   0));
    dir_tab.push_back(plan(REQ_STORE,     0,   2, 255,   0,   0));
    dir_tab.push_back(plan(REQ_CONVERT,   3,   8,   0, 255, 255));
    dir_tab.push_back(plan(REQ_CONVERT,   3,  11, 255, 255, 255));
    // last grid entry and last image pixel
    dir_tab.push_back(plan(REQ_STORE,    31,  39,   0, 8'hAA, 8'h55));
    dir_tab.push_back(plan(REQ_CONVERT, 127, 159, 128,   0,   0));
    // store (1,0); the off-grid stores after it must leave (1,0) and (0,0) alone
    dir_tab.push_back(plan(REQ_STORE,     1,   0,   0,  10, 200));
    dir_tab.push_back(plan(REQ_STORE,    32,   0,   0,   1,   2));
    dir_tab.push_back(plan(REQ_STORE,     0,  40,   0,   3,   4));
    dir_tab.push_back(plan(REQ_STORE,   127, 255, 255,   5,   6));
    dir_tab.push_back(plan(REQ_CONVERT,   4,   0, 100,   0,   0));
    dir_tab.push_back(plan(REQ_CONVERT,   0,   0, 100,   0,   0));
    // convert off the chroma grid uses zero chroma
    dir_tab.push_back(plan(REQ_CONVERT,   5, 160,   0, 255, 255));
    dir_tab.push_back(plan(REQ_CONVERT, 127, 255, 255,   0,   0));
    // store immediately followed by a convert that reads it
    dir_tab.push_back(plan(REQ_STORE,     2,   2,   0,  90, 170));
    dir_tab.push_back(plan(REQ_CONVERT,   8,   8,  77,   0,   0));
    dir_tab.push_back(plan(REQ_CONVERT,  11,  11, 200,   0,   0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    // top of the offset ranges; the sink stalls long here to back up the input
    program_offsets(7'd112, 5'd16);
    long_hold_req = 1'b1;
    random_run(70);
    program_offsets(7'd0, 5'd0);
    random_run(70);
    // widest values the registers can hold
    program_offsets(7'd127, 5'd31);
    random_run(60);
    program_offsets(7'($urandom_range(0, 112)), 5'($urandom_range(0, 16)));
    random_run(40);
    calm = 1'b1;
    random_run(40);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fb_writes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- ycbcr_to_rgb555_upscale_writer_core.f -----
rtl/yc2rgb_pkg.sv
rtl/yc2rgb_ram.sv
rtl/yc2rgb_cvt.sv
rtl/ycbcr_to_rgb555_upscale_writer_core.sv
dv/testbench.sv
